@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the sync detector.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/bssd_pkg.sv @@
// Types and constants for the bitstream sync detector and word packer.
// No dependencies.
package bssd_pkg;

  // Default window and dummy run length
  localparam int unsigned HEADER_WINDOW_DEF = 256;
  localparam int unsigned DUMMY_RUN_DEF     = 32;

  // Bus-width check patterns, first byte in bits 7:0
  localparam logic [63:0] PAT_PLAIN   = 64'h1122_0044_0000_00bb;
  localparam logic [63:0] PAT_SWAPPED = 64'h4400_2211_bb00_0000;

  // Sync burst: all-ones words, then the two sync words (same for both orders)
  localparam int unsigned SYNC_BURST = 10;
  localparam int unsigned FILL_BEATS = 8;
  localparam int unsigned BEAT_W     = $clog2(SYNC_BURST);
  localparam logic [31:0] SYNC_W0    = 32'h0000_00bb;
  localparam logic [31:0] SYNC_W1    = 32'h1122_0044;

  localparam logic [2:0] FULL_COUNT = 3'd4;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_NO_DUMMY = 2'd1,
    ST_BAD_SYNC = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  byte_count;
    status_e     status;
    logic        run_last;
  } out_item_t;

  // What one accepted item asks the output side to emit
  typedef struct packed {
    logic      is_sync;
    out_item_t item;
  } desc_t;

endpackage

@@ hw/rtl/bitstream_sync_detect_and_swap.sv @@
// Results are registered in the current slot, or the spare slot while that is busy.
// Throughput: one item per cycle; a sync match emits a burst of 10 results, one per
// cycle while the output accepts, and input ready drops once the spare result slot
// behind that burst is full. Items that cause no result never touch the result slots.
// Reset (async, active low) clears all stream state and empties both result slots.
`include "assert_macros.svh"

module bitstream_sync_detect_and_swap import bssd_pkg::*; #(
  parameter int unsigned HEADER_WINDOW = HEADER_WINDOW_DEF,
  parameter int unsigned DUMMY_RUN     = DUMMY_RUN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic  take, push, free;
  desc_t desc;
  logic  mid_burst, full_data, err_shown, err_clean;

  assign in_ready_o = free;
  assign take       = in_valid_i && free;

  bssd_core #(
    .HEADER_WINDOW(HEADER_WINDOW),
    .DUMMY_RUN    (DUMMY_RUN)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .item_i(in_data_i),
    .push_o(push),
    .desc_o(desc)
  );

  bssd_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .desc_i     (desc),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Classify the shown result for the checks below
  assign mid_burst = out_valid_o && !out_data_o.run_last;
  assign full_data = (out_data_o.status == ST_DATA) && (out_data_o.byte_count == FULL_COUNT);
  assign err_shown = out_valid_o &&
                     (out_data_o.status == ST_NO_DUMMY || out_data_o.status == ST_BAD_SYNC);
  assign err_clean = (out_data_o.byte_count == 3'd0) && (out_data_o.out_word == 32'h0) &&
                     out_data_o.run_last;

  // Spare slot is only used while the current slot is busy
  `ASSERT_IMPLIES(a_spare_behind_cur, clk_i, rst_ni, !in_ready_o, out_valid_o)
  // Only burst words come without run_last, and they are full data words
  `ASSERT_IMPLIES(a_mid_burst_data, clk_i, rst_ni, mid_burst, full_data)
  // Error results carry no bytes and end the run
  `ASSERT_IMPLIES(a_error_empty, clk_i, rst_ni, err_shown, err_clean)
  // Output valid stays up after any mid-burst result, taken or held
  `ASSERT_NEXT(a_burst_holds, clk_i, rst_ni, mid_burst, out_valid_o)

endmodule

@@ hw/rtl/bssd_core.sv @@
// Stream state for the sync detector: dummy run scan, sync check, word packing.
// Depends on bssd_pkg.
module bssd_core import bssd_pkg::*; #(
  parameter int unsigned HEADER_WINDOW = HEADER_WINDOW_DEF,
  parameter int unsigned DUMMY_RUN     = DUMMY_RUN_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  output logic     push_o,
  output desc_t    desc_o
);

  localparam int unsigned PosW = $clog2(HEADER_WINDOW);
  localparam int unsigned RunW = $clog2(DUMMY_RUN + 1);
  localparam logic [PosW-1:0] PosLast = PosW'(HEADER_WINDOW - 8);
  localparam logic [RunW-1:0] RunMax  = RunW'(DUMMY_RUN);

  typedef enum logic [1:0] {
    PH_SCAN  = 2'd0,
    PH_CHECK = 2'd1,
    PH_DATA  = 2'd2,
    PH_SKIP  = 2'd3
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [RunW-1:0] run_q, run_d;
  logic [55:0]     sync_q, sync_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            swap_q, swap_d;
  logic [23:0]     grp_q, grp_d;
  logic [1:0]      fill_q, fill_d;

  logic [7:0]  b;
  logic        last;
  logic        scan_end, run_full, is_ff, scan_to_check, scan_fail;
  logic [63:0] full;
  logic [31:0] word, word_sw;
  logic        has;

  assign b        = item_i.in_byte;
  assign last     = item_i.end_of_stream;
  assign scan_end = (pos_q >= PosLast);
  assign run_full = (run_q == RunMax);
  assign is_ff    = (b == 8'hff);
  assign full     = {b, sync_q};
  assign word     = {b, grp_q};
  assign word_sw  = {word[7:0], word[15:8], word[23:16], word[31:24]};

  // Scan outcome for this byte
  assign scan_to_check = scan_end ? run_full : (!is_ff && run_full);
  assign scan_fail     = scan_end && !run_full;

  // Next state and the result descriptor
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    run_d   = run_q;
    sync_d  = sync_q;
    cnt_d   = cnt_q;
    swap_d  = swap_q;
    grp_d   = grp_q;
    fill_d  = fill_q;
    has     = 1'b0;
    desc_o  = '0;
    desc_o.item.status = ST_DATA;

    unique case (phase_q)
      PH_SCAN: begin
        pos_d = pos_q + 1'b1;
        if (scan_end) begin
          phase_d = run_full ? PH_CHECK : PH_SKIP;
        end else if (is_ff) begin
          if (!run_full) run_d = run_q + 1'b1;
        end else if (run_full) begin
          phase_d = PH_CHECK;
        end else begin
          run_d = '0;
        end
        if (scan_fail) begin
          has = 1'b1;
          desc_o.item.status   = ST_NO_DUMMY;
          desc_o.item.run_last = 1'b1;
        end else if (scan_to_check) begin
          sync_d = {b, 48'h0};
          cnt_d  = 3'd1;
          if (last) begin
            has = 1'b1;
            desc_o.item.status   = ST_BAD_SYNC;
            desc_o.item.run_last = 1'b1;
          end
        end else if (last) begin
          has = 1'b1;
          desc_o.item.status   = ST_NO_DUMMY;
          desc_o.item.run_last = 1'b1;
        end
      end
      PH_CHECK: begin
        sync_d = {b, sync_q[55:8]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 3'd7) begin
          has = 1'b1;
          if (full == PAT_PLAIN || full == PAT_SWAPPED) begin
            desc_o.is_sync = 1'b1;
            phase_d = PH_DATA;
            swap_d  = (full == PAT_SWAPPED);
            grp_d   = '0;
            fill_d  = '0;
          end else begin
            desc_o.item.status   = ST_BAD_SYNC;
            desc_o.item.run_last = 1'b1;
            phase_d = PH_SKIP;
          end
        end else if (last) begin
          has = 1'b1;
          desc_o.item.status   = ST_BAD_SYNC;
          desc_o.item.run_last = 1'b1;
        end
      end
      PH_DATA: begin
        if (fill_q == 2'd3) begin
          has = 1'b1;
          desc_o.item.out_word   = swap_q ? word_sw : word;
          desc_o.item.byte_count = FULL_COUNT;
          desc_o.item.run_last   = 1'b1;
          grp_d  = '0;
          fill_d = '0;
        end else begin
          case (fill_q)
            2'd0:    grp_d[7:0]   = b;
            2'd1:    grp_d[15:8]  = b;
            default: grp_d[23:16] = b;
          endcase
          fill_d = fill_q + 1'b1;
          if (last) begin
            has = 1'b1;
            desc_o.item.out_word   = {8'h00, grp_d};
            desc_o.item.byte_count = {1'b0, fill_q} + 3'd1;
            desc_o.item.status     = ST_TRUNC;
            desc_o.item.run_last   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // Return to the start after the last byte of a stream
    if (last) begin
      phase_d = PH_SCAN;
      pos_d   = '0;
      run_d   = '0;
      sync_d  = '0;
      cnt_d   = '0;
      swap_d  = 1'b0;
      grp_d   = '0;
      fill_d  = '0;
    end
  end

  assign push_o = take_i && has;

  // Hold stream state, advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCAN;
      pos_q   <= '0;
      run_q   <= '0;
      sync_q  <= '0;
      cnt_q   <= '0;
      swap_q  <= 1'b0;
      grp_q   <= '0;
      fill_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      sync_q  <= sync_d;
      cnt_q   <= cnt_d;
      swap_q  <= swap_d;
      grp_q   <= grp_d;
      fill_q  <= fill_d;
    end
  end

endmodule

@@ hw/rtl/bssd_out.sv @@
// Result register with one spare slot; expands a sync descriptor into its burst.
// Depends on bssd_pkg.
module bssd_out import bssd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  desc_t     desc_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [BEAT_W-1:0] BeatLast = BEAT_W'(SYNC_BURST - 1);
  localparam logic [BEAT_W-1:0] BeatW0   = BEAT_W'(FILL_BEATS);

  logic              cur_valid_q, pend_valid_q;
  desc_t             cur_q, pend_q;
  logic [BEAT_W-1:0] beat_q;
  logic              fire, cur_done, slot_free;

  assign fire      = cur_valid_q && out_ready_i;
  assign cur_done  = fire && (!cur_q.is_sync || beat_q == BeatLast);
  assign slot_free = !cur_valid_q || cur_done;
  assign free_o    = !pend_valid_q;

  // Build the shown result from the current descriptor
  always_comb begin
    out_data_o = cur_q.item;
    if (cur_q.is_sync) begin
      out_data_o.byte_count = FULL_COUNT;
      out_data_o.status     = ST_DATA;
      out_data_o.run_last   = (beat_q == BeatLast);
      if (beat_q < BeatW0) begin
        out_data_o.out_word = '1;
      end else if (beat_q == BeatW0) begin
        out_data_o.out_word = SYNC_W0;
      end else begin
        out_data_o.out_word = SYNC_W1;
      end
    end
  end

  assign out_valid_o = cur_valid_q;

  // Advance beats, refill current slot from the spare slot or the new item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      beat_q       <= '0;
    end else if (slot_free) begin
      beat_q <= '0;
      if (pend_valid_q) begin
        cur_valid_q  <= 1'b1;
        pend_valid_q <= push_i;
      end else begin
        cur_valid_q <= push_i;
      end
    end else begin
      if (fire) beat_q <= beat_q + 1'b1;
      if (push_i) pend_valid_q <= 1'b1;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (pend_valid_q) begin
        cur_q <= pend_q;
        if (push_i) pend_q <= desc_i;
      end else if (push_i) begin
        cur_q <= desc_i;
      end
    end else if (push_i) begin
      pend_q <= desc_i;
    end
  end

endmodule

@@ sim/tb_bitstream_sync_detect_and_swap.sv @@
`timescale 1ns / 100ps
// Testbench for bitstream_sync_detect_and_swap: byte streams with dummy runs, sync patterns
// in both orders, broken headers and short tails, checked against an in-bench stream model.
// Depends on bssd_pkg and the block's RTL.
module tb_bitstream_sync_detect_and_swap;
  import bssd_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 30;

  typedef enum logic [1:0] {SP_SCAN, SP_CHECK, SP_DATA, SP_SKIP} stream_phase_e;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t    byte_q[$];
  out_item_t   predicted_q[$];
  int unsigned items_queued   = 0;
  int unsigned results_seen   = 0;
  int unsigned err_cnt        = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // Stream model state
  stream_phase_e sp;
  int unsigned   hdr_pos;
  int unsigned   ff_run;
  int unsigned   sync_cnt;
  int unsigned   grp_fill;
  logic [63:0]   sync_buf;
  logic [31:0]   grp;
  bit            swap_on;

  bitstream_sync_detect_and_swap u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ERROR result %0d %s: got %h, want %h", $time, results_seen, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [31:0] flip_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  task automatic clear_stream_state();
    sp       = SP_SCAN;
    hdr_pos  = 0;
    ff_run   = 0;
    sync_cnt = 0;
    grp_fill = 0;
    sync_buf = '0;
    grp      = '0;
    swap_on  = 1'b0;
  endtask

  task automatic add_result(input logic [31:0] word, input logic [2:0] cnt,
                            input status_e st, input logic last);
    out_item_t r;
    r.out_word   = word;
    r.byte_count = cnt;
    r.status     = st;
    r.run_last   = last;
    predicted_q.push_back(r);
  endtask

  // Advance the stream model by one accepted item and queue the words it yields
  task automatic predict_stream_byte(input in_item_t it);
    logic [7:0]  b;
    logic [31:0] w0;
    logic [31:0] w1;
    bit          eos;
    b   = it.in_byte;
    eos = it.end_of_stream;
    case (sp)
      SP_SCAN: begin
        if (hdr_pos >= HEADER_WINDOW_DEF - 8) begin
          if (ff_run >= DUMMY_RUN_DEF) begin
            sp = SP_CHECK;
          end else begin
            add_result('0, '0, ST_NO_DUMMY, 1'b1);
            sp = SP_SKIP;
          end
        end else if (b == 8'hff) begin
          if (ff_run < DUMMY_RUN_DEF) ff_run++;
        end else if (ff_run >= DUMMY_RUN_DEF) begin
          sp = SP_CHECK;
        end else begin
          ff_run = 0;
        end
        hdr_pos++;
        if (sp == SP_CHECK) begin
          sync_buf = {56'd0, b};
          sync_cnt = 1;
          if (eos) add_result('0, '0, ST_BAD_SYNC, 1'b1);
        end else if (sp == SP_SCAN && eos) begin
          add_result('0, '0, ST_NO_DUMMY, 1'b1);
        end
      end
      SP_CHECK: begin
        sync_buf |= {56'd0, b} << (8 * sync_cnt);
        sync_cnt++;
        if (sync_cnt >= 8) begin
          if (sync_buf == PAT_PLAIN || sync_buf == PAT_SWAPPED) begin
            swap_on = (sync_buf == PAT_SWAPPED);
            w0 = sync_buf[31:0];
            w1 = sync_buf[63:32];
            if (swap_on) begin
              w0 = flip_bytes(w0);
              w1 = flip_bytes(w1);
            end
            repeat (8) add_result('1, FULL_COUNT, ST_DATA, 1'b0);
            add_result(w0, FULL_COUNT, ST_DATA, 1'b0);
            add_result(w1, FULL_COUNT, ST_DATA, 1'b1);
            sp       = SP_DATA;
            grp      = '0;
            grp_fill = 0;
          end else begin
            add_result('0, '0, ST_BAD_SYNC, 1'b1);
            sp = SP_SKIP;
          end
        end else if (eos) begin
          add_result('0, '0, ST_BAD_SYNC, 1'b1);
        end
      end
      SP_DATA: begin
        if (grp_fill >= 3) begin
          w0 = {b, grp[23:0]};
          if (swap_on) w0 = flip_bytes(w0);
          add_result(w0, FULL_COUNT, ST_DATA, 1'b1);
          grp      = '0;
          grp_fill = 0;
        end else begin
          grp |= {24'd0, b} << (8 * grp_fill);
          grp_fill++;
          if (eos) add_result(grp, 3'(grp_fill), ST_TRUNC, 1'b1);
        end
      end
      default: ;
    endcase
    if (eos) clear_stream_state();
  endtask

  // Stream building blocks
  task automatic push_byte(input logic [7:0] b, input bit eos);
    in_item_t it;
    it.in_byte       = b;
    it.end_of_stream = eos;
    byte_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_run(input int unsigned n);
    repeat (n) push_byte(8'hff, 1'b0);
  endtask

  task automatic push_noise(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(254)), 1'b0);
  endtask

  // Send the first n bytes of a sync pattern, marking the last one as end of stream if asked
  task automatic push_pattern(input logic [63:0] p, input int unsigned n, input bit eos);
    for (int unsigned i = 0; i < n; i++) push_byte(p[8*i +: 8], eos && (i == n - 1));
  endtask

  task automatic push_data(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
  endtask

  task automatic pick_pattern(output logic [63:0] p);
    p = $urandom_range(1) ? PAT_SWAPPED : PAT_PLAIN;
  endtask

  // Queue one random stream: mostly well-formed, the rest broken in various ways
  task automatic add_random_stream();
    int unsigned kind;
    int unsigned run;
    int unsigned n;
    logic [63:0] pat;
    kind = $urandom_range(99);
    run  = ($urandom_range(9) == 0) ? $urandom_range(90, 60) : $urandom_range(36, 32);
    pick_pattern(pat);
    push_noise($urandom_range(3));
    if (kind < 55) begin
      n = $urandom_range(22);
      push_run(run);
      push_pattern(pat, 8, n == 0);
      push_data(n);
    end else if (kind < 65) begin
      push_run(run);
      push_pattern(pat ^ (64'd1 << $urandom_range(63)), 8, 1'b0);
      push_data($urandom_range(4, 1));
    end else if (kind < 75) begin
      push_run(run);
      push_pattern(pat, $urandom_range(7, 1), 1'b1);
    end else if (kind < 87) begin
      push_run($urandom_range(31, 1));
      push_noise(1);
      push_data($urandom_range(6, 1));
    end else begin
      push_data($urandom_range(12, 1));
    end
  endtask

  // Block the stimulus until every queued item has gone and every result has arrived
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || predicted_q.size() != 0) @(posedge clk);
  endtask

  // Driver: offer the next item, or idle, whenever the input slot is free
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_stream_byte(in_data);
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_q.size() == 0) begin
          flag_mismatch("unexpected result", out_data.out_word, '0);
        end else begin
          want = predicted_q.pop_front();
          if (out_data.out_word !== want.out_word)
            flag_mismatch("out_word", out_data.out_word, want.out_word);
          if (out_data.byte_count !== want.byte_count)
            flag_mismatch("byte_count", 32'(out_data.byte_count), 32'(want.byte_count));
          if (out_data.status !== want.status)
            flag_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.run_last !== want.run_last)
            flag_mismatch("run_last", 32'(out_data.run_last), 32'(want.run_last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when work is pending but nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else if (byte_q.size() != 0 || in_valid || predicted_q.size() != 0) quiet++;
    end
    $display("%0t ERROR no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned start_cnt;
    clear_stream_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed streams: early ends, both orders, short tails, broken sync
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b1);
    push_run(32);
    push_pattern(PAT_PLAIN, 8, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h5a, 1'b0);
    push_byte(8'ha5, 1'b0);
    push_byte(8'hff, 1'b1);
    push_noise(1);
    push_run(33);
    push_pattern(PAT_SWAPPED, 8, 1'b0);
    push_data(7);
    push_run(32);
    push_pattern(PAT_PLAIN ^ 64'h0000_0100_0000_0000, 8, 1'b0);
    push_data(2);
    push_run(32);
    push_pattern(PAT_PLAIN, 3, 1'b1);
    wait_drained();

    // Random streams under each idling mix, draining between mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 54; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 54; end
        default: begin send_gap_pct = 37; recv_stall_pct = 37; end
      endcase
      start_cnt = items_queued;
      while (items_queued - start_cnt < PHASE_ITEMS) add_random_stream();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_q.size() != 0)
      flag_mismatch("results never delivered", predicted_q.size(), '0);
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
